// ----- sv/npf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npf_pkg: shared types and constants for the pattern finder
// Register indexes, action codes, cell control and pattern byte lookup.
// ----------------------------------------------------------------------------
package npf_pkg;

    localparam int PATTERN_MAX_DEF  = 8;
    localparam int DOC_SIZE_MAX_DEF = 65536;

    localparam logic [5:0] MATCH_LIMIT = 6'd50;

    // configuration register indexes
    localparam logic [1:0] CFG_PAT_LEN   = 2'd0;
    localparam logic [1:0] CFG_PAT_BYTES = 2'd1;
    localparam logic [1:0] CFG_MAX_MATCH = 2'd2;

    // item actions
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef struct packed {
        logic shift;   // take the neighbor's byte
        logic clear;   // back to zero (end of document)
    } t_cell_ctrl;

    // pattern character i; positions past the 64-bit register read as zero
    function automatic logic [7:0] pattern_char(input logic [63:0] pb, input logic [4:0] i);
        if (i >= 5'd8) begin
            return 8'h00;
        end
        return pb[{i[2:0], 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

// ----- sv/npf_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npf_cell: one window cell
// Holds one document byte, passes it on at each shift and compares the
// incoming byte against its pattern character.
// ----------------------------------------------------------------------------
module npf_cell
    import npf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire logic [7:0] i_byte,      // byte from the neighbor (new value)
    input  wire logic [7:0] i_pat_char,
    input  wire logic       i_active,    // cell lies inside the pattern
    output logic      [7:0] o_byte,
    output logic            o_eq
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.clear) begin
            n_byte = 8'h00;
        end else if (i_ctrl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    // compare against the byte this cell holds after the shift
    assign o_eq   = !i_active || (i_byte == i_pat_char);

endmodule
`default_nettype wire

// ----- sv/nonoverlapping_pattern_finder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nonoverlapping_pattern_finder: streaming non-overlapping pattern search
// Reports each occurrence of a configured pattern in a byte stream.
// ----------------------------------------------------------------------------
// Feed the document one text byte per item; the block reports every match of
// the configured pattern (up to PATTERN_MAX bytes, first character in the low
// byte of pattern_bytes) scanning left to right without overlap, giving start
// and end position and the running match count. An end-of-document item
// returns a summary (is_final = 1, match_total) and clears the document state.
// A pattern length of zero, or longer than PATTERN_MAX, finds nothing; at most
// max_matches (capped at 50) matches are reported per document; bytes after
// DOC_SIZE_MAX are dropped silently. Rate: one item per cycle while results are
// drained. The window is a chain of PATTERN_MAX byte cells that shift on every
// text byte inside the size limit and compare in parallel; the result sits in
// a single output register, and a new item is taken whenever that register is
// empty or being drained in the same cycle. Output valid rises in the cycle
// after input accept. Configuration writes are always taken (ready stays high)
// and apply from the next item; write only while the block is idle.
// ----------------------------------------------------------------------------
module nonoverlapping_pattern_finder
    import npf_pkg::*;
#(
    parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
    parameter int DOC_SIZE_MAX = DOC_SIZE_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // input item channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_text_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_match_start,
    output logic [16:0]      o_match_end,
    output logic [5:0]       o_match_total,
    output logic             o_is_final
);

    localparam int POS_W = $clog2(DOC_SIZE_MAX + 1);

    // ---------------- configuration registers ----------------
    logic [3:0]  r_pat_len;
    logic [63:0] r_pat_bytes;
    logic [5:0]  r_max_match;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len   <= 4'd0;
            r_pat_bytes <= 64'd0;
            r_max_match <= MATCH_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PAT_LEN:   r_pat_len   <= i_cfg_data[3:0];
                CFG_PAT_BYTES: r_pat_bytes <= i_cfg_data;
                CFG_MAX_MATCH: r_max_match <= i_cfg_data[5:0];
                default:       ;  // index past the register list: ignored
            endcase
        end
    end

    // ---------------- document state ----------------
    logic [POS_W-1:0] r_pos;         // text bytes taken so far (within the size limit)
    logic [POS_W-1:0] r_next_start;  // earliest start allowed for next match
    logic [5:0]       r_matches;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] n_next_start;
    logic [5:0]       n_matches;

    logic       in_acc;
    logic       take_byte;   // text byte inside the size limit
    logic       doc_end;
    t_cell_ctrl cell_ctrl;

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign doc_end    = in_acc && (i_action == ACT_END);
    assign take_byte  = in_acc && (i_action == ACT_BYTE)
                        && (32'(r_pos) < DOC_SIZE_MAX);

    assign cell_ctrl.shift = take_byte;
    assign cell_ctrl.clear = doc_end;

    // ---------------- window cell chain ----------------
    logic [7:0]             w_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_eq;

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic [7:0] w_in;
        logic       w_active;
        logic [4:0] w_idx;

        if (j == 0) begin : g_head
            assign w_in = i_text_byte;
        end else begin : g_link
            assign w_in = w_byte[j-1];
        end

        // window byte j (newest first) lines up with pattern char len-1-j
        assign w_active = 32'(r_pat_len) > j;
        assign w_idx    = 5'(r_pat_len) - 5'd1 - 5'(j);

        npf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl),
            .i_byte     (w_in),
            .i_pat_char (pattern_char(r_pat_bytes, w_idx)),
            .i_active   (w_active),
            .o_byte     (w_byte[j]),
            .o_eq       (w_eq[j])
        );
    end

    // ---------------- match decision ----------------
    logic [5:0]       limit;
    logic [POS_W-1:0] end_pos;
    logic [POS_W-1:0] len_ext;
    logic [POS_W-1:0] start_pos;
    logic             len_ok;
    logic             hit;

    assign limit     = (r_max_match > MATCH_LIMIT) ? MATCH_LIMIT : r_max_match;
    assign end_pos   = r_pos + POS_W'(1);
    assign len_ext   = POS_W'(r_pat_len);
    assign start_pos = end_pos - len_ext;
    assign len_ok    = (r_pat_len != 4'd0) && (32'(r_pat_len) <= PATTERN_MAX);
    assign hit       = take_byte && len_ok && (r_matches < limit)
                       && (end_pos >= len_ext) && (start_pos >= r_next_start)
                       && (&w_eq);

    always_comb begin
        n_pos        = r_pos;
        n_next_start = r_next_start;
        n_matches    = r_matches;
        if (doc_end) begin
            n_pos        = '0;
            n_next_start = '0;
            n_matches    = 6'd0;
        end else if (take_byte) begin
            n_pos = end_pos;
            if (hit) begin
                n_next_start = end_pos;
                n_matches    = r_matches + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_next_start <= '0;
            r_matches    <= 6'd0;
        end else begin
            r_pos        <= n_pos;
            r_next_start <= n_next_start;
            r_matches    <= n_matches;
        end
    end

    // ---------------- output register ----------------
    logic        r_out_valid;
    logic [15:0] r_start;
    logic [16:0] r_end;
    logic [5:0]  r_total;
    logic        r_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= doc_end || hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (doc_end) begin
            r_start <= 16'd0;
            r_end   <= 17'd0;
            r_total <= r_matches;
            r_final <= 1'b1;
        end else if (hit) begin
            r_start <= 16'(start_pos);
            r_end   <= 17'(end_pos);
            r_total <= r_matches + 6'd1;
            r_final <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_start = r_start;
    assign o_match_end   = r_end;
    assign o_match_total = r_total;
    assign o_is_final    = r_final;

    // ---------------- assertions ----------------
    a_match_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matches <= MATCH_LIMIT)
        else $error("match count above limit");

    a_next_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_start <= r_pos)
        else $error("next start ahead of position");

    a_doc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        doc_end |=> (r_pos == '0) && (r_matches == 6'd0) && o_out_valid && o_is_final)
        else $error("end of document did not clear state or give summary");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("item taken while result stalled");

endmodule
`default_nettype wire
